// File: hw/rtl/rspe_pkg.sv
// Shared types, constants and GF(256) helpers for the Reed-Solomon parity encoder.
// No dependencies; every other file of the block imports this package.
package rspe_pkg;

	localparam int MAX_PARITY  = 32;
	localparam int PW          = $clog2(MAX_PARITY + 1);
	localparam int CFG_W       = 6;
	localparam int RESET_COUNT = (10 > MAX_PARITY) ? MAX_PARITY : 10;
	localparam logic [7:0] FIELD_POLY_LOW = 8'h1D;

	typedef logic [MAX_PARITY-1:0][7:0] gf_vec_t;

	typedef struct packed {
		logic          busy;
		logic [PW-1:0] count;
	} gen_stat_t;

	typedef struct packed {
		logic          load;
		logic [PW-1:0] count;
	} snap_ctl_t;

	function automatic logic [7:0] gf_xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY_LOW : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] acc;
		acc = '0;
		x   = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) acc ^= x;
			x = gf_xtime(x);
		end
		return acc;
	endfunction

	// zero means one, anything above the register depth clamps to it
	function automatic logic [PW-1:0] limit_count(input logic [CFG_W-1:0] v);
		if (v == '0) return PW'(1);
		if (int'(v) > MAX_PARITY) return PW'(MAX_PARITY);
		return PW'(v);
	endfunction

endpackage

// File: hw/rtl/rs_parity_encoder_core.sv
// Reed-Solomon parity encoder over GF(256): one data word per cycle while tready is high,
// parity_count parity out. The last data word is registered in the input stage; once the
// output shift register is free (it sends one parity word per cycle while m_axis_tready is
// high), its parity set is loaded into it and the first parity word is presented. Earlier
// words of the next message are taken while a set is being sent. Reset (arst_n low, async)
// clears the parity state, sets parity_count to 10 and rebuilds the generator; that build,
// and each after a config write, holds s_axis_tready low as it runs (one root per cycle).
module rs_parity_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic       s_axis_tlast,   // end_of_message
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] parity_byte
	output logic       m_axis_tlast,   // last_parity
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [rspe_pkg::CFG_W-1:0] cfg_data
);
	import rspe_pkg::*;

	gen_stat_t gen;
	gf_vec_t   coefs;
	snap_ctl_t snap;
	gf_vec_t   snap_vec;
	logic      snap_free;
	logic      idle;

	// hold config words while a generator build, a message or an offered data word is pending
	assign cfg_ready = !gen.busy && idle && !s_axis_tvalid;

	rspe_coef_gen u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.stat      (gen),
		.coefs     (coefs)
	);

	rspe_lfsr u_lfsr (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.gen       (gen),
		.coefs     (coefs),
		.snap_free (snap_free),
		.snap      (snap),
		.snap_vec  (snap_vec),
		.idle      (idle)
	);

	rspe_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.snap      (snap),
		.snap_vec  (snap_vec),
		.snap_free (snap_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

`ifndef SYNTHESIS
	a_build_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		gen.busy |-> !s_axis_tready)
		else $error("input accepted during generator build");

	a_cfg_starts_build: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (gen.busy && !s_axis_tready))
		else $error("config write did not start a generator build");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		snap.load |-> snap_free)
		else $error("parity set loaded over one still being sent");

	a_load_shows_output: assert property (@(posedge clk) disable iff (!arst_n)
		snap.load |=> m_axis_tvalid)
		else $error("loaded parity set not presented");
`endif

endmodule

// File: hw/rtl/rspe_coef_gen.sv
// Parity count register and generator polynomial builder (one root per cycle).
// Depends on rspe_pkg.
module rspe_coef_gen (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [rspe_pkg::CFG_W-1:0] cfg_data,
	output rspe_pkg::gen_stat_t stat,
	output rspe_pkg::gf_vec_t   coefs
);
	import rspe_pkg::*;

	logic          busy_q;
	logic [PW-1:0] count_q;
	logic [PW-1:0] left_q;
	logic [7:0]    root_q;
	gf_vec_t       coef_q;
	gf_vec_t       coef_next;

	// multiply the polynomial by (x + root); coef_q[j] holds the term j+1 degrees below the leading one
	always_comb begin
		coef_next[0] = coef_q[0] ^ root_q;
		for (int j = 1; j < MAX_PARITY; j++) begin
			coef_next[j] = coef_q[j] ^ gf_mul(coef_q[j-1], root_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			count_q <= PW'(RESET_COUNT);
			left_q  <= PW'(RESET_COUNT);
			root_q  <= 8'h01;
			coef_q  <= '0;
		end else if (cfg_write) begin
			busy_q  <= 1'b1;
			count_q <= limit_count(cfg_data);
			left_q  <= limit_count(cfg_data);
			root_q  <= 8'h01;
			coef_q  <= '0;
		end else if (busy_q) begin
			coef_q <= coef_next;
			root_q <= gf_xtime(root_q);
			left_q <= left_q - PW'(1);
			busy_q <= (left_q != PW'(1));
		end
	end

	assign stat.busy  = busy_q;
	assign stat.count = count_q;
	assign coefs      = coef_q;

endmodule

// File: hw/rtl/rspe_lfsr.sv
// Input register and parity shift register: one data word folded in per cycle while no build or full output holds it.
// Depends on rspe_pkg.
module rspe_lfsr (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_data,
	input  logic                in_last,
	input  rspe_pkg::gen_stat_t gen,
	input  rspe_pkg::gf_vec_t   coefs,
	input  logic                snap_free,
	output rspe_pkg::snap_ctl_t snap,
	output rspe_pkg::gf_vec_t   snap_vec,
	output logic                idle
);
	import rspe_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       mid_q;
	gf_vec_t    rem_q;
	gf_vec_t    rem_next;
	logic [7:0] fb;
	logic       adv;

	assign fb = data_s1 ^ rem_q[0];

	always_comb begin
		for (int i = 0; i < MAX_PARITY - 1; i++) begin
			rem_next[i] = ((PW'(i + 1) < gen.count) ? rem_q[i+1] : 8'h00)
				^ gf_mul(coefs[i], fb);
		end
		rem_next[MAX_PARITY-1] = gf_mul(coefs[MAX_PARITY-1], fb);
	end

	// a last word waits until the output side can take the finished parity
	assign adv      = valid_s1 && (!last_s1 || snap_free);
	assign in_ready = !gen.busy && (!valid_s1 || adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mid_q    <= 1'b0;
			rem_q    <= '0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv) begin
				rem_q <= last_s1 ? '0 : rem_next;
				mid_q <= !last_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
			last_s1 <= in_last;
		end
	end

	assign snap.load  = adv && last_s1;
	assign snap.count = gen.count;
	assign snap_vec   = rem_next;
	assign idle       = !valid_s1 && !mid_q;

endmodule

// File: hw/rtl/rspe_out.sv
// Output shift register: holds one finished parity set and sends it a word at a time.
// Depends on rspe_pkg.
module rspe_out (
	input  logic                clk,
	input  logic                arst_n,
	input  rspe_pkg::snap_ctl_t snap,
	input  rspe_pkg::gf_vec_t   snap_vec,
	output logic                snap_free,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_data,
	output logic                out_last
);
	import rspe_pkg::*;

	logic          busy_q;
	logic [PW-1:0] cnt_q;
	gf_vec_t       par_q;
	logic          take;

	assign take      = busy_q && out_ready;
	assign out_valid = busy_q;
	assign out_data  = par_q[0];
	assign out_last  = (cnt_q == PW'(1));
	assign snap_free = !busy_q || (take && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (snap.load) begin
			busy_q <= 1'b1;
			cnt_q  <= snap.count;
		end else if (take) begin
			busy_q <= !out_last;
			cnt_q  <= cnt_q - PW'(1);
		end
	end

	// advance toward index 0, highest-degree term leaves first
	always_ff @(posedge clk) begin
		if (snap.load) begin
			par_q <= snap_vec;
		end else if (take) begin
			for (int i = 0; i < MAX_PARITY - 1; i++) par_q[i] <= par_q[i+1];
			par_q[MAX_PARITY-1] <= 8'h00;
		end
	end

endmodule

// File: dv/tb_rs_parity_encoder_core.sv
// Self-checking testbench for rs_parity_encoder_core: stream messages in, check parity words out.
// Depends on rspe_pkg and the RTL of the encoder only; predicts parity with its own GF(256) math.
`timescale 1ns / 100ps

module tb_rs_parity_encoder_core;
	import rspe_pkg::MAX_PARITY;
	import rspe_pkg::CFG_W;

	typedef enum logic {ROW_CFG, ROW_DATA} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [7:0] value;       // data word, or count written for ROW_CFG
		logic       last;
		logic       fixed;       // parity typed in: every parity word equals fixed_byte
		logic [7:0] fixed_byte;
	} stim_row_t;

	typedef struct {
		logic [7:0] parity;
		logic       last;
	} parity_word_t;

	logic             clk;
	logic             arst_n        = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata  = '0;   // [7:0] data_byte
	logic             s_axis_tlast  = 1'b0; // end_of_message
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [7:0]       m_axis_tdata;         // [7:0] parity_byte
	logic             m_axis_tlast;         // last_parity
	logic             cfg_valid     = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data      = '0;

	// predictor state
	logic [7:0]   rem_bytes [MAX_PARITY];
	logic [7:0]   gen_coef  [MAX_PARITY];
	int unsigned  par_count;
	parity_word_t parity_q [$];
	stim_row_t    dir_rows [$];

	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;
	int unsigned err_count = 0;

	rs_parity_encoder_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Verification failed");
		$finish;
	end

	// Horner form, most significant bit of b first, reduced by x^8+x^4+x^3+x^2+1
	function automatic logic [7:0] gf256_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = '0;
		for (int i = 7; i >= 0; i--) begin
			acc = {acc[6:0], 1'b0} ^ (acc[7] ? 8'h1D : 8'h00);
			if (b[i]) acc ^= a;
		end
		return acc;
	endfunction

	task automatic build_gen_poly(input int unsigned n);
		logic [7:0] poly [MAX_PARITY+1];
		logic [7:0] root;
		for (int j = 0; j <= MAX_PARITY; j++) poly[j] = '0;
		poly[0] = 8'h01;
		root    = 8'h01;
		// multiply in (x + alpha^i), highest degree first
		for (int i = 0; i < n; i++) begin
			for (int j = i + 1; j > 0; j--) poly[j] ^= gf256_mul(poly[j-1], root);
			root = gf256_mul(root, 8'h02);
		end
		for (int i = 0; i < MAX_PARITY; i++) gen_coef[i] = (i < n) ? poly[i+1] : 8'h00;
	endtask

	task automatic set_parity_count(input logic [CFG_W-1:0] v);
		if (v == '0) par_count = 1;
		else if (v > MAX_PARITY) par_count = MAX_PARITY;
		else par_count = 32'(v);
		build_gen_poly(par_count);
	endtask

	task automatic encode_byte(input logic [7:0] d, input logic l, input logic fixed,
			input logic [7:0] fixed_byte);
		logic [7:0]   fb;
		parity_word_t w;
		fb = d ^ rem_bytes[0];
		for (int i = 0; i + 1 < par_count; i++) rem_bytes[i] = rem_bytes[i+1];
		rem_bytes[par_count-1] = 8'h00;
		for (int i = 0; i < par_count; i++) rem_bytes[i] ^= gf256_mul(gen_coef[i], fb);
		if (l) begin
			for (int i = 0; i < par_count; i++) begin
				w.parity = fixed ? fixed_byte : rem_bytes[i];
				w.last   = (i + 1 == par_count);
				parity_q.push_back(w);
			end
			for (int i = 0; i < MAX_PARITY; i++) rem_bytes[i] = 8'h00;
		end
	endtask

	task automatic push_word(input logic [7:0] d, input logic l, input logic fixed,
			input logic [7:0] fixed_byte);
		if ($urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tlast  <= l;
		do @(posedge clk); while (!s_axis_tready);
		encode_byte(d, l, fixed, fixed_byte);
	endtask

	// hold off the sender until every parity word has come out, then let the pipe settle
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (parity_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_count(input logic [CFG_W-1:0] v);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		set_parity_count(v);
	endtask

	task automatic add_row(input row_kind_t k, input logic [7:0] v, input logic l,
			input logic fixed, input logic [7:0] fixed_byte);
		stim_row_t r;
		r.kind       = k;
		r.value      = v;
		r.last       = l;
		r.fixed      = fixed;
		r.fixed_byte = fixed_byte;
		dir_rows.push_back(r);
	endtask

	task automatic send_random_message(output int unsigned n_words);
		int unsigned len;
		logic [7:0]  d;
		len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12);
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0:       d = 8'h00;
				1:       d = 8'hFF;
				default: d = 8'($urandom_range(0, 255));
			endcase
			push_word(d, (i + 1 == len), 1'b0, 8'h00);
		end
		n_words = len;
	endtask

	// sink: random backpressure, check every accepted parity word
	always @(posedge clk) begin
		parity_word_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (parity_q.size() == 0) begin
				$display("%0t: unexpected parity word %02h last %0b", $time,
					m_axis_tdata, m_axis_tlast);
				err_count++;
			end else begin
				w = parity_q.pop_front();
				if (m_axis_tdata !== w.parity || m_axis_tlast !== w.last) begin
					$display("%0t: parity mismatch: expected %02h last %0b, got %02h last %0b",
						$time, w.parity, w.last, m_axis_tdata, m_axis_tlast);
					err_count++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	initial begin
		int unsigned sent;
		int unsigned msgs;
		int unsigned n;
		for (int i = 0; i < MAX_PARITY; i++) rem_bytes[i] = 8'h00;
		set_parity_count(CFG_W'(10));

		// all-zero message gives all-zero parity; with one parity word the parity is
		// the XOR of the message
		add_row(ROW_DATA, 8'h00, 1'b1, 1'b1, 8'h00);
		add_row(ROW_DATA, 8'hFF, 1'b1, 1'b0, 8'h00);
		add_row(ROW_DATA, 8'hAA, 1'b0, 1'b0, 8'h00);
		add_row(ROW_DATA, 8'h55, 1'b0, 1'b0, 8'h00);
		add_row(ROW_DATA, 8'h80, 1'b1, 1'b0, 8'h00);
		add_row(ROW_CFG,  8'd0,  1'b0, 1'b0, 8'h00);   // zero count taken as one
		add_row(ROW_DATA, 8'hFF, 1'b1, 1'b1, 8'hFF);
		add_row(ROW_DATA, 8'h12, 1'b0, 1'b0, 8'h00);
		add_row(ROW_DATA, 8'h34, 1'b1, 1'b1, 8'h26);
		add_row(ROW_DATA, 8'h00, 1'b1, 1'b1, 8'h00);
		add_row(ROW_CFG,  8'd63, 1'b0, 1'b0, 8'h00);   // clamps to the register depth
		add_row(ROW_DATA, 8'hFF, 1'b0, 1'b0, 8'h00);
		add_row(ROW_DATA, 8'h00, 1'b0, 1'b0, 8'h00);
		add_row(ROW_DATA, 8'h01, 1'b1, 1'b0, 8'h00);
		add_row(ROW_DATA, 8'h80, 1'b1, 1'b0, 8'h00);
		add_row(ROW_CFG,  8'd33, 1'b0, 1'b0, 8'h00);
		add_row(ROW_DATA, 8'h7F, 1'b1, 1'b0, 8'h00);
		add_row(ROW_CFG,  8'd32, 1'b0, 1'b0, 8'h00);
		add_row(ROW_DATA, 8'h00, 1'b1, 1'b1, 8'h00);
		add_row(ROW_CFG,  8'd1,  1'b0, 1'b0, 8'h00);
		add_row(ROW_DATA, 8'hA5, 1'b1, 1'b1, 8'hA5);
		add_row(ROW_CFG,  8'd2,  1'b0, 1'b0, 8'h00);
		add_row(ROW_DATA, 8'h01, 1'b1, 1'b0, 8'h00);
		add_row(ROW_CFG,  8'd31, 1'b0, 1'b0, 8'h00);
		add_row(ROW_DATA, 8'h3C, 1'b1, 1'b0, 8'h00);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) write_count(dir_rows[i].value[CFG_W-1:0]);
			else push_word(dir_rows[i].value, dir_rows[i].last, dir_rows[i].fixed,
				dir_rows[i].fixed_byte);
		end

		for (int ph = 0; ph < 4; ph++) begin
			drain_results();
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 65; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 65; end
				default: begin gap_pct = 36; stall_pct = 36; end
			endcase
			sent = 0;
			msgs = 0;
			while (sent < 108) begin
				if (msgs % 6 == 0) begin
					case ($urandom_range(0, 3))
						0:       write_count(CFG_W'($urandom_range(0, 1)));
						1:       write_count(CFG_W'($urandom_range(32, 63)));
						default: write_count(CFG_W'($urandom_range(0, 63)));
					endcase
				end else if (msgs % 6 == 3 && $urandom_range(0, 1) == 0) begin
					drain_results();
				end
				send_random_message(n);
				sent = sent + n;
				msgs++;
			end
		end

		s_axis_tvalid <= 1'b0;
		while (parity_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (err_count == 0 && parity_q.size() == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
